>>> sv/tcc_pkg.sv
// Shared constants, types and helper functions for the telegram CRC checker.
`default_nettype none

package tcc_pkg;

  localparam logic [7:0]  LineFeedChar = 8'h0A;
  localparam logic [7:0]  SlashChar    = 8'h2F;
  localparam logic [7:0]  BangChar     = 8'h21;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [2:0]  HexMaxDigits = 3'd4;

  // Decoded hex character
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_dig_t;

  // Per-byte result of the line parser
  typedef struct packed {
    logic        line_done;
    logic        crc_line;
    logic        crc_ok;
    logic [15:0] received_crc;
  } line_res_t;

  // Reflected CRC-16 over one byte, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic hex_dig_t hex_digit(input logic [7:0] b);
    hex_dig_t d;
    d.valid = 1'b1;
    d.value = 4'h0;
    if (b inside {[8'h30:8'h39]}) begin
      d.value = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d.value = b[3:0] + 4'd9;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/telegram_crc_checker.sv
// Top level of the smart-meter telegram CRC-16 checker.
`default_nettype none

// Takes one telegram byte per item and returns one result item per byte.
// The CRC is a reflected CRC-16 (poly 0xA001, no final xor), restarted by
// '/' and covering it; every '!' latches the CRC including itself. A line
// starting with '!' collects up to four hex digits, stopping at the first
// non-hex character. On a line feed the result flags the line end, whether
// it was a CRC line, and whether the collected value matches the latched
// CRC (a CRC line with no digits is a mismatch). computed_crc always shows
// the latched CRC after the byte. Throughput is one item per cycle while the
// receiver keeps up. Results are registered: the byte is held in the input
// register while the byte-wide CRC fold and line update run into the result
// register. The work stage fires when the input register holds a byte and
// the result register is empty or being drained; if the receiver stalls, the
// input and result registers fill with two items and the input stalls too.
module telegram_crc_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             line_done_o,
  output logic             crc_line_o,
  output logic             crc_ok_o,
  output logic      [15:0] computed_crc_o,
  output logic      [15:0] received_crc_o
);
  import tcc_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // result register
  logic        out_valid_q;
  line_res_t   res_q;
  logic [15:0] comp_q;

  logic        advance;
  logic [15:0] latched_d;
  line_res_t   res_d;

  // work stage fires when it holds a byte and the result slot frees up
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tcc_crc u_crc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .byte_i      (in_byte_q),
    .latched_d_o (latched_d)
  );

  tcc_line u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .byte_i    (in_byte_q),
    .latched_i (latched_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q  <= res_d;
      comp_q <= latched_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_done_o    = res_q.line_done;
  assign crc_line_o     = res_q.crc_line;
  assign crc_ok_o       = res_q.crc_ok;
  assign received_crc_o = res_q.received_crc;
  assign computed_crc_o = comp_q;

endmodule

`default_nettype wire

>>> sv/tcc_crc.sv
// Running CRC-16 register and the CRC latched at each '!'.
`default_nettype none

module tcc_crc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] latched_d_o
);
  import tcc_pkg::*;

  logic [15:0] running_q, running_d;
  logic [15:0] latched_q;
  logic [15:0] seed;

  always_comb begin
    seed        = (byte_i == SlashChar) ? 16'h0000 : running_q;
    running_d   = crc_fold(seed, byte_i);
    latched_d_o = (byte_i == BangChar) ? running_d : latched_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      latched_q <= '0;
    end else if (en_i) begin
      running_q <= running_d;
      latched_q <= latched_d_o;
    end
  end

endmodule

`default_nettype wire

>>> sv/tcc_line.sv
// Line tracker: detects CRC lines, collects hex digits, compares at line feed.
`default_nettype none

module tcc_line (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [15:0]         latched_i,
  output tcc_pkg::line_res_t       res_o
);
  import tcc_pkg::*;

  logic        at_start_q, at_start_d;
  logic        bang_q, bang_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] hex_q, hex_d;
  logic        stopped_q, stopped_d;
  logic        seen_q, seen_d;
  hex_dig_t    dig;

  always_comb begin
    dig        = hex_digit(byte_i);
    at_start_d = at_start_q;
    bang_d     = bang_q;
    pos_d      = pos_q;
    hex_d      = hex_q;
    stopped_d  = stopped_q;
    seen_d     = seen_q;
    res_o      = '0;

    if (byte_i == LineFeedChar) begin
      res_o.line_done = 1'b1;
      if (bang_q && !at_start_q) begin
        res_o.crc_line     = 1'b1;
        res_o.received_crc = hex_q;
        res_o.crc_ok       = seen_q && (hex_q == latched_i);
      end
      at_start_d = 1'b1;
      bang_d     = 1'b0;
      pos_d      = '0;
      hex_d      = '0;
      stopped_d  = 1'b0;
      seen_d     = 1'b0;
    end else if (at_start_q) begin
      at_start_d = 1'b0;
      bang_d     = (byte_i == BangChar);
    end else if (bang_q && !stopped_q && (pos_q < HexMaxDigits)) begin
      if (!dig.valid) begin
        stopped_d = 1'b1;
      end else begin
        hex_d  = {hex_q[11:0], dig.value};
        seen_d = 1'b1;
        pos_d  = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      bang_q     <= 1'b0;
      pos_q      <= '0;
      hex_q      <= '0;
      stopped_q  <= 1'b0;
      seen_q     <= 1'b0;
    end else if (en_i) begin
      at_start_q <= at_start_d;
      bang_q     <= bang_d;
      pos_q      <= pos_d;
      hex_q      <= hex_d;
      stopped_q  <= stopped_d;
      seen_q     <= seen_d;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_telegram_crc_checker.sv
// Self-checking testbench for the telegram CRC-16 checker: directed, stall and random traffic.

module tb_telegram_crc_checker;

  localparam logic [7:0]  LfChar     = tcc_pkg::LineFeedChar;
  localparam logic [7:0]  SlashByte  = tcc_pkg::SlashChar;
  localparam logic [7:0]  BangByte   = tcc_pkg::BangChar;
  localparam logic [15:0] Poly       = tcc_pkg::CrcPoly;
  localparam logic [7:0]  CrChar     = 8'h0D;
  localparam int          ItemTarget = 1950;
  localparam int          CycleLimit = 300000;

  // How the checksum line of a generated telegram ends up
  typedef enum int {CrcGood, CrcFlipped, CrcShort, CrcTrailing} crc_tail_e;

  typedef struct packed {
    logic        line_done;
    logic        crc_line;
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } line_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        line_done_o;
  logic        crc_line_o;
  logic        crc_ok_o;
  logic [15:0] computed_crc_o;
  logic [15:0] received_crc_o;

  // Shadow copy of the checker state
  logic [15:0] crc_run     = '0;
  logic [15:0] crc_latched = '0;
  logic        line_start  = 1'b1;
  logic        bang_ln     = 1'b0;
  logic [2:0]  hex_cnt     = '0;
  logic [15:0] hex_acc     = '0;
  logic        hex_halt    = 1'b0;
  logic        hex_any     = 1'b0;

  line_result_t pending_results[$];
  int           err_cnt      = 0;
  int           items_sent   = 0;
  int           cycle_cnt    = 0;
  int           hold_off_len = 0;
  bit           idle_on      = 1'b1;

  telegram_crc_checker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_done_o   (line_done_o),
    .crc_line_o    (crc_line_o),
    .crc_ok_o      (crc_ok_o),
    .computed_crc_o(computed_crc_o),
    .received_crc_o(received_crc_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("FAIL telegram_crc_checker");
      $finish;
    end
  end

  // Reflected CRC-16, one bit per round, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ Poly) : (c >> 1);
    end
    return c;
  endfunction

  // Hex digit value, or -1 for anything else
  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - 48;
    if (b >= "A" && b <= "F") return int'(b) - 55;
    if (b >= "a" && b <= "f") return int'(b) - 87;
    return -1;
  endfunction

  task automatic predict_line_result(input logic [7:0] b);
    line_result_t r;
    logic         first;
    int           d;
    r = '0;
    first = line_start;
    if (b == SlashByte) crc_run = '0;
    crc_run = crc16_step(crc_run, b);
    if (b == BangByte) crc_latched = crc_run;
    if (b == LfChar) begin
      r.line_done = 1'b1;
      if (bang_ln && !first) begin
        r.crc_line     = 1'b1;
        r.received_crc = hex_acc;
        r.crc_ok       = hex_any && (hex_acc == crc_latched);
      end
      line_start = 1'b1;
      bang_ln    = 1'b0;
      hex_cnt    = '0;
      hex_acc    = '0;
      hex_halt   = 1'b0;
      hex_any    = 1'b0;
    end else if (first) begin
      line_start = 1'b0;
      bang_ln    = (b == BangByte);
    end else if (bang_ln && !hex_halt && hex_cnt < 3'd4) begin
      d = hex_nibble(b);
      if (d < 0) begin
        hex_halt = 1'b1;
      end else begin
        hex_acc = {hex_acc[11:0], 4'(d)};
        hex_any = 1'b1;
        hex_cnt = hex_cnt + 3'd1;
      end
    end
    r.computed_crc = crc_latched;
    pending_results.push_back(r);
  endtask

  // Offer one byte and hold it until the checker takes it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_line_result(b);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Mostly printable text, now and then any byte at all
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == BangByte || b == SlashByte);
    return b;
  endfunction

  // Checksum line; the expected value is what the '!' about to be sent latches
  task automatic send_crc_line(input crc_tail_e tail);
    logic [15:0] v;
    string       digits;
    int          ndig;
    v = crc16_step(crc_run, BangByte);
    if (tail == CrcFlipped) v = v ^ (16'h1 << $urandom_range(0, 15));
    digits = $urandom_range(0, 1) ? $sformatf("%04X", v) : $sformatf("%04x", v);
    ndig = (tail == CrcShort) ? $urandom_range(0, 3) : 4;
    send_byte(BangByte);
    for (int i = 0; i < ndig; i++) send_byte(digits[i]);
    if (tail == CrcTrailing) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte($urandom_range(0, 1) ? digits[$urandom_range(0, 3)] : text_byte());
      end
    end
    if ($urandom_range(0, 3) != 0) send_byte(CrChar);
    send_byte(LfChar);
  endtask

  task automatic send_text_line();
    repeat ($urandom_range(0, 10)) send_byte(text_byte());
    if ($urandom_range(0, 3) != 0) send_byte(CrChar);
    send_byte(LfChar);
  endtask

  task automatic send_telegram();
    int        pick;
    crc_tail_e tail;
    send_byte(SlashByte);
    send_text_line();
    repeat ($urandom_range(0, 3)) send_text_line();
    pick = $urandom_range(0, 9);
    if (pick < 6) tail = CrcGood;
    else if (pick == 6) tail = CrcFlipped;
    else if (pick == 7) tail = CrcShort;
    else tail = CrcTrailing;
    send_crc_line(tail);
  endtask

  // Junk with plenty of line feeds, bangs and slashes mixed in
  task automatic send_noise(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) send_byte(LfChar);
      else if (pick == 2) send_byte(BangByte);
      else if (pick == 3) send_byte(SlashByte);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Empty line, '!' in mid line latching the CRC, byte extremes
  task automatic test_line_basics();
    send_byte(LfChar);
    send_byte(SlashByte);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(BangByte);
    send_byte(LfChar);
  endtask

  // Checksum line with no digits, with too many digits, and one that matches
  task automatic test_crc_line_forms();
    send_byte(BangByte);
    send_byte(CrChar);
    send_byte(LfChar);
    send_str("!aB9f7\n");
    send_crc_line(CrcGood);
  endtask

  // Receiver holds off long enough for the checker to fill and stall its input
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_off_len = 80;
    send_telegram();
    send_telegram();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    while (items_sent < ItemTarget) begin
      if (items_sent >= ItemTarget - 300) idle_on = 1'b0;
      else if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 20));
      else send_telegram();
    end
  endtask

  // Result side: random stall bursts, plus the long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        hold_off_len--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result item with no expectation, expected none, got %h/%h/%h/%h/%h",
                 $time, line_done_o, crc_line_o, crc_ok_o, computed_crc_o, received_crc_o);
      end else begin
        want = pending_results.pop_front();
        check_field("line_done", 16'(want.line_done), 16'(line_done_o));
        check_field("crc_line", 16'(want.crc_line), 16'(crc_line_o));
        check_field("crc_ok", 16'(want.crc_ok), 16'(crc_ok_o));
        check_field("computed_crc", want.computed_crc, computed_crc_o);
        check_field("received_crc", want.received_crc, received_crc_o);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_line_basics();
    test_crc_line_forms();
    test_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS telegram_crc_checker");
    end else begin
      $display("FAIL telegram_crc_checker");
    end
    $finish;
  end

endmodule
